// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also watches the reset cycles
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/rrts_pkg.sv
// types and constants of the round-robin task slot scheduler
package rrts_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int STACK_BYTES = 4096;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SP_W        = 32;
  localparam int SLOT_PORT_W = 3;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  // saved context frame: four words, seven argument words, one more word
  localparam logic [SP_W-1:0] FRAME_BYTES = SP_W'(4 + 4 + 4 + 4 + 4 * 7 + 4);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic      rr_found;
    slot_idx_t rr_slot;
    logic      free_found;
    slot_idx_t free_slot;
  } pick_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [SLOT_PORT_W-1:0] slot;
    logic [SP_W-1:0]        sp;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

endpackage

// File: rtl/core/round_robin_task_slot_scheduler_top.sv
// top level of the round-robin task slot scheduler
//
// usage
//   cfg channel: one beat writes stack_region_base; cfg_ready is always high.
//     write it only while the block is idle.
//   in channel: operation (0 add, 1 switch, 2 exit) plus saved_stack_pointer.
//   out channel: status, slot and stack_pointer, exactly one beat per input beat,
//     in input order.
// result path and throughput
//   add, exit and unknown codes: result registered in the output register, or in the
//     hold register while out is stalled; one item per cycle while out is not stalled.
//   switch: S_READ for the synchronous read of the saved-pointer memory, in_ready low,
//     then the output register (write of old pointer and read of next share the accept edge).
// reset
//   synchronous rst: only slot 0 is live, slot 0 is current, base is zero.
//   the saved-pointer memory is not cleared; an entry's read data is used only
//   after it was written.
// stalls
//   a result waiting on out_ready does not block the input: one more result
//   parks in a hold register, and only then in_ready drops (it is also low in S_READ).
module round_robin_task_slot_scheduler_top import rrts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SP_W-1:0]         cfg_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic [SP_W-1:0]         saved_stack_pointer,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [SLOT_PORT_W-1:0]  slot,
  output logic [SP_W-1:0]         stack_pointer
);

  localparam logic [SLOT_COUNT-1:0] FLAGS_RESET = {{(SLOT_COUNT-1){1'b1}}, 1'b0};

  // control state
  state_t                state, state_next;
  slot_idx_t             cur_slot;
  logic [SLOT_COUNT-1:0] finished;
  logic [SP_W-1:0]       base;

  // saved stack pointers, synchronous read
  logic [SP_W-1:0]       mem [SLOT_COUNT];
  logic [SP_W-1:0]       mem_rdata;
  logic                  mem_we;
  slot_idx_t             mem_waddr;
  logic [SP_W-1:0]       mem_wdata;
  slot_idx_t             mem_raddr;

  // switch bookkeeping carried into the read cycle
  logic                  sw_found;
  logic                  sw_fwd;
  logic [SP_W-1:0]       sw_sp;
  slot_idx_t             sw_slot;

  // result path
  res_t                  out_res;
  res_t                  pend;
  res_t                  res_cmb;
  logic                  res_new;
  logic                  out_free;
  logic                  out_load;
  logic                  pend_load;
  logic                  accept;
  logic [SP_W-1:0]       init_sp;
  pick_t                 pick;

  rrts_pick u_pick (
    .live (~finished),
    .cur  (cur_slot),
    .pick (pick)
  );

  assign cfg_ready     = 1'b1;
  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_free      = !out_valid || out_ready;
  assign status        = out_res.status;
  assign slot          = out_res.slot;
  assign stack_pointer = out_res.sp;

  // initial pointer of the claimed slot: its stack top minus one frame
  assign init_sp = base
                 + (SP_W'(pick.free_slot) + SP_W'(1)) * SP_W'(STACK_BYTES)
                 - FRAME_BYTES;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_slot;
    mem_wdata = saved_stack_pointer;
    mem_raddr = pick.rr_slot;
    if (accept && operation == OP_ADD && pick.free_found) begin
      mem_we    = 1'b1;
      mem_waddr = pick.free_slot;
      mem_wdata = init_sp;
    end else if (accept && operation == OP_SWITCH) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // next state and result selection
  always_comb begin
    state_next = state;
    res_new    = 1'b0;
    res_cmb    = pend;
    out_load   = 1'b0;
    pend_load  = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_ADD: begin
              res_new = 1'b1;
              if (pick.free_found) begin
                res_cmb.status = STAT_OK;
                res_cmb.slot   = SLOT_PORT_W'(pick.free_slot);
                res_cmb.sp     = init_sp;
              end else begin
                res_cmb.status = STAT_FULL;
                res_cmb.slot   = '0;
                res_cmb.sp     = '0;
              end
            end
            OP_SWITCH: begin
              state_next = S_READ;
            end
            default: begin
              // exit and unused codes report the current slot
              res_new        = 1'b1;
              res_cmb.status = STAT_OK;
              res_cmb.slot   = SLOT_PORT_W'(cur_slot);
              res_cmb.sp     = '0;
            end
          endcase
        end
      end
      S_READ: begin
        res_new = 1'b1;
        if (sw_found) begin
          res_cmb.status = STAT_OK;
          res_cmb.slot   = SLOT_PORT_W'(sw_slot);
          res_cmb.sp     = sw_fwd ? sw_sp : mem_rdata;
        end else begin
          res_cmb.status = STAT_EMPTY;
          res_cmb.slot   = SLOT_PORT_W'(sw_slot);
          res_cmb.sp     = sw_sp;
        end
      end
      S_HOLD: begin
        res_new = 1'b1;
        res_cmb = pend;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (res_new) begin
      if (out_free) begin
        out_load   = 1'b1;
        state_next = S_IDLE;
      end else begin
        pend_load  = (state != S_HOLD);
        state_next = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
      finished <= FLAGS_RESET;
      base     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
      if (accept) begin
        case (operation)
          OP_ADD: begin
            if (pick.free_found) begin
              finished[pick.free_slot] <= 1'b0;
            end
          end
          OP_SWITCH: begin
            if (pick.rr_found) begin
              cur_slot <= pick.rr_slot;
            end
          end
          OP_EXIT: begin
            finished[cur_slot] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // switch context: picked slot, and a bypass when it is the slot just saved
  always_ff @(posedge clk) begin
    if (accept && operation == OP_SWITCH) begin
      sw_found <= pick.rr_found;
      sw_fwd   <= (pick.rr_slot == cur_slot);
      sw_sp    <= saved_stack_pointer;
      sw_slot  <= pick.rr_found ? pick.rr_slot : cur_slot;
    end
  end

  // output register and hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res_cmb;
    end
    if (pend_load) begin
      pend <= res_cmb;
    end
  end

endmodule

// File: rtl/core/rrts_pick.sv
// slot selection: round-robin next live slot and lowest finished slot
module rrts_pick import rrts_pkg::*; (
  input  logic [SLOT_COUNT-1:0] live,
  input  slot_idx_t             cur,
  output pick_t                 pick
);

  logic [2*SLOT_COUNT-1:0] live2;
  logic [SLOT_COUNT-1:0]   rot;
  logic [SLOT_COUNT-1:0]   fin;
  slot_idx_t               start;
  slot_idx_t               rr_ofs;
  slot_idx_t               fr_idx;
  logic                    rr_any;
  logic                    fr_any;
  logic [SLOT_W:0]         sum;

  always_comb begin
    start = (cur == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cur + SLOT_W'(1);
    live2 = {live, live};
    // rotate so the slot after the current one sits at bit 0
    rot   = live2[start +: SLOT_COUNT];
    fin   = ~live;

    rr_any = 1'b0;
    rr_ofs = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (rot[i]) begin
        rr_any = 1'b1;
        rr_ofs = SLOT_W'(i);
      end
    end

    fr_any = 1'b0;
    fr_idx = '0;
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (fin[j]) begin
        fr_any = 1'b1;
        fr_idx = SLOT_W'(j);
      end
    end

    sum = {1'b0, start} + {1'b0, rr_ofs};
    if (sum >= (SLOT_W + 1)'(SLOT_COUNT)) begin
      sum = sum - (SLOT_W + 1)'(SLOT_COUNT);
    end

    pick.rr_found   = rr_any;
    pick.rr_slot    = sum[SLOT_W-1:0];
    pick.free_found = fr_any;
    pick.free_slot  = fr_idx;
  end

endmodule

// File: rtl/core/rrts_checker.sv
// port-level checks of the scheduler and their bind to the top level
`include "assert_macros.svh"

module rrts_checker import rrts_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [SP_W-1:0]        cfg_data,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [OP_W-1:0]        operation,
  input logic [SP_W-1:0]        saved_stack_pointer,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [SLOT_PORT_W-1:0] slot,
  input logic [SP_W-1:0]        stack_pointer
);

  // a stalled result stays
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(status) && $stable(slot) && $stable(stack_pointer))
  // a full table reports slot zero and a null pointer
  `ASSERT_IMPLY(a_full_zero, clk, rst, out_valid && status == STAT_FULL, slot == '0 && stack_pointer == '0)
  // a switch takes the memory read cycle before the next beat
  `ASSERT_NEXT(a_switch_busy, clk, rst, in_valid && in_ready && operation == OP_SWITCH, !in_ready)
  // no result right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind round_robin_task_slot_scheduler_top rrts_checker u_rrts_checker (.*);

// File: bench/tb_round_robin_task_slot_scheduler_top.sv
// self-checking testbench for the round-robin task slot scheduler top level
`timescale 1ns / 1ps

module tb_round_robin_task_slot_scheduler_top;
  import rrts_pkg::*;

  // operation code with no meaning: the block answers it without a state change
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // context frame pushed below each slot's stack top on add
  localparam int unsigned CTX_FRAME_BYTES = 4 * 4 + 4 * 7 + 4;
  // settle time after the last reply, with margin over the slowest (switch) path
  localparam int SETTLE_CYCLES  = 6;
  // cycles with no beat on any channel before the run is given up
  localparam int WATCHDOG_LIMIT = 4000;

  // ---------------------------------------------------------------------------
  // slot table predictor plus the queue of replies still owed by the block
  // ---------------------------------------------------------------------------
  class sched_scoreboard;
    bit              slot_done [SLOT_COUNT];
    logic [SP_W-1:0] slot_sp   [SLOT_COUNT];
    int unsigned     cur_slot;
    logic [SP_W-1:0] region_base;
    res_t            owed_replies [$];
    int              errors;

    function new();
      for (int k = 0; k < SLOT_COUNT; k++) begin
        slot_done[k] = (k != 0);
        slot_sp[k]   = '0;
      end
      cur_slot    = 0;
      region_base = '0;
      errors      = 0;
    endfunction

    function void set_base(logic [SP_W-1:0] v);
      region_base = v;
    endfunction

    // advance the slot table by one request and queue the reply it gives
    function void note_request(logic [OP_W-1:0] op, logic [SP_W-1:0] sp_in);
      res_t            r;
      bit              hit;
      int unsigned     cand;
      logic [SP_W-1:0] top;
      r.status = STAT_OK;
      r.slot   = SLOT_PORT_W'(cur_slot);
      r.sp     = '0;
      hit      = 1'b0;
      case (op)
        OP_ADD: begin
          // lowest finished slot wins
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (!hit && slot_done[k]) begin
              hit          = 1'b1;
              top          = region_base + SP_W'((k + 1) * STACK_BYTES);
              top          = top - SP_W'(CTX_FRAME_BYTES);
              slot_sp[k]   = top;
              slot_done[k] = 1'b0;
              r.slot       = SLOT_PORT_W'(k);
              r.sp         = top;
            end
          end
          if (!hit) begin
            r.status = STAT_FULL;
            r.slot   = '0;
          end
        end
        OP_SWITCH: begin
          slot_sp[cur_slot] = sp_in;
          // search after the current slot, current slot last
          for (int k = 1; k <= SLOT_COUNT; k++) begin
            cand = (cur_slot + k) % SLOT_COUNT;
            if (!hit && !slot_done[cand]) begin
              hit      = 1'b1;
              cur_slot = cand;
              r.slot   = SLOT_PORT_W'(cand);
              r.sp     = slot_sp[cand];
            end
          end
          if (!hit) begin
            r.status = STAT_EMPTY;
            r.sp     = sp_in;
          end
        end
        OP_EXIT: begin
          slot_done[cur_slot] = 1'b1;
        end
        default: begin
        end
      endcase
      owed_replies.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
    endtask

    // compare one reply beat with the oldest owed reply
    task check_reply(logic [STATUS_W-1:0] st, logic [SLOT_PORT_W-1:0] sl,
                     logic [SP_W-1:0] sp);
      res_t e;
      if (owed_replies.size() == 0) begin
        flag_mismatch("reply beat with no request outstanding");
      end else begin
        e = owed_replies.pop_front();
        if (st !== e.status)
          flag_mismatch($sformatf("status got %0d exp %0d", st, e.status));
        if (sl !== e.slot)
          flag_mismatch($sformatf("slot got %0d exp %0d", sl, e.slot));
        if (sp !== e.sp)
          flag_mismatch($sformatf("stack_pointer got %h exp %h", sp, e.sp));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // signals and the block
  // ---------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SP_W-1:0]        cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        operation;
  logic [SP_W-1:0]        saved_stack_pointer;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_PORT_W-1:0] slot;
  logic [SP_W-1:0]        stack_pointer;

  sched_scoreboard sb;
  int              quiet_cycles;

  round_robin_task_slot_scheduler_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .operation           (operation),
    .saved_stack_pointer (saved_stack_pointer),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .slot                (slot),
    .stack_pointer       (stack_pointer)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // monitor: every beat is seen at the rising edge, before the block updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_base(cfg_data);
      // a request beat never answers in its own cycle, so note it first
      if (in_valid && in_ready) sb.note_request(operation, saved_stack_pointer);
      if (out_valid && out_ready) sb.check_reply(status, slot, stack_pointer);
      // watchdog: any beat on any channel counts as progress
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** round_robin_task_slot_scheduler_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: out_ready follows a pattern of spans, each with its own mode
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      // a dead stall gets a shorter maximum span than the other modes
      span = (mode == 3) ? $urandom_range(10, 40) : $urandom_range(8, 120);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks, entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // hold a request beat until it is taken; valid stays up on return
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SP_W-1:0] sp);
    in_valid            <= 1'b1;
    operation           <= op;
    saved_stack_pointer <= sp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender gap; zero keeps valid up for a back-to-back beat
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // block goes idle: nothing owed, then the switch latency and some margin
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.owed_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(input logic [SP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // weighted op choice; the unused code keeps bit 1 and bit 0 high together
  function automatic logic [OP_W-1:0] pick_op(int aw, int sw, int ew, int jw);
    int r;
    r = $urandom_range(0, aw + sw + ew + jw - 1);
    if (r < aw) return OP_ADD;
    if (r < aw + sw) return OP_SWITCH;
    if (r < aw + sw + ew) return OP_EXIT;
    return OP_UNUSED;
  endfunction

  // pointers lean on the extremes now and then
  function automatic logic [SP_W-1:0] pick_sp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int              aw, sw, ew, jw;
    int              count;
    int              left;
    int              burst;
    logic [SP_W-1:0] base_v;

    sb                  = new();
    quiet_cycles        = 0;
    rst                 = 1'b1;
    cfg_valid           = 1'b0;
    cfg_data            = '0;
    in_valid            = 1'b0;
    operation           = OP_ADD;
    saved_stack_pointer = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, top of the address space so every stack top wraps
    write_base('1);
    send_request(OP_SWITCH, '1);             // only slot 0 live: back to itself
    send_request(OP_EXIT, 32'h1234_5678);
    send_request(OP_SWITCH, 32'hA5A5_A5A5);  // no live slot left
    send_request(OP_EXIT, '0);               // exit of a slot already finished
    send_request(OP_UNUSED, 32'h5A5A_5A5A);
    for (int k = 0; k < SLOT_COUNT; k++)
      send_request(OP_ADD, $urandom);        // fill slot 0 first, then the rest
    send_request(OP_ADD, '1);                // table full
    send_request(OP_SWITCH, '0);
    send_request(OP_SWITCH, '1);
    send_request(OP_EXIT, '1);
    send_request(OP_SWITCH, 32'h8000_0000);
    send_request(OP_ADD, '0);                // reclaim the slot just finished
    send_request(OP_UNUSED, '1);
    send_request(OP_SWITCH, $urandom);

    // random phases, each with its own base and op mix
    for (int p = 0; p < 6; p++) begin
      drain_replies();
      case (p)
        0: begin base_v = '0;            aw = 30; sw = 50; ew = 15; jw = 5; count = 300; end
        1: begin base_v = '1;            aw = 50; sw = 40; ew = 5;  jw = 5; count = 300; end
        2: begin base_v = $urandom;      aw = 15; sw = 45; ew = 35; jw = 5; count = 300; end
        3: begin base_v = 32'hFFFF_F000; aw = 30; sw = 50; ew = 15; jw = 5; count = 300; end
        4: begin base_v = 32'h8000_0000; aw = 25; sw = 55; ew = 15; jw = 5; count = 350; end
        default: begin
          base_v = $urandom; aw = 30; sw = 45; ew = 20; jw = 5; count = 350;
        end
      endcase
      write_base(base_v);
      left = count;
      while (left > 0) begin
        // bursts of random length, sometimes long and gapless
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) send_request(pick_op(aw, sw, ew, jw), pick_sp());
        left -= burst;
        pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
      end
    end

    drain_replies();
    if (sb.owed_replies.size() != 0) sb.flag_mismatch("replies still owed at the end");
    if (sb.errors == 0) begin
      $display("** round_robin_task_slot_scheduler_top: PASSED **");
    end else begin
      $display("** round_robin_task_slot_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_pick.sv
rtl/core/round_robin_task_slot_scheduler_top.sv
rtl/core/rrts_checker.sv
bench/tb_round_robin_task_slot_scheduler_top.sv
